### sv/sbcr_pkg.sv
// package for the swept box collision resolve core
// widths and slab time limits; no dependencies
package sbcr_pkg;
    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 8;
    localparam int TIME_BITS      = 16;
    localparam int QBITS          = TIME_BITS + 1;
    localparam int TW             = 19;
    localparam logic signed [TW-1:0] T_ONE = 19'sd65536;
    localparam logic signed [TW-1:0] T_SAT = 19'sd131072;
endpackage

### sv/sbcr_div.sv
// pipelined restoring divider for one slab time, one quotient bit per stage
// depends on sbcr_pkg
module sbcr_div #(
    parameter int NW = 34,
    parameter int DW = 32
) (
    input  logic                        clk,
    input  logic                        en,
    input  logic signed [NW-1:0]        num,
    input  logic signed [DW-1:0]        den,
    output logic signed [sbcr_pkg::TW-1:0] quo
);
    import sbcr_pkg::*;
    localparam int QB = QBITS;
    localparam int RW = DW + 1;
    localparam int SW = (NW + 15 > RW) ? NW + 15 : RW;
    logic [RW-1:0]  rem_reg [QB+1];
    logic [QB-1:0]  q_reg   [QB+1];
    logic [DW-1:0]  d_reg   [QB+1];
    logic           neg_reg [QB+1];
    logic           sat_reg [QB+1];
    logic           zero_reg[QB+1];
    logic [NW-1:0]  an;
    logic [DW-1:0]  ad;
    logic [SW-1:0]  an_sh;
    logic signed [TW-1:0] res;

    always_comb
    begin
        an    = num[NW-1] ? NW'(-num) : NW'(num);
        ad    = den[DW-1] ? DW'(-den) : DW'(den);
        an_sh = SW'({an, 15'd0});
        res = '0;
        if (!zero_reg[QB])
        begin
            if (sat_reg[QB])
                res = neg_reg[QB] ? -T_SAT : T_SAT;
            else if (neg_reg[QB])
                res = -TW'({1'b0, q_reg[QB]}) - TW'(rem_reg[QB] != '0);
            else
                res = TW'({1'b0, q_reg[QB]});
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= RW'(an_sh);
            q_reg[0]    <= '0;
            d_reg[0]    <= ad;
            neg_reg[0]  <= num[NW-1] ^ den[DW-1];
            zero_reg[0] <= an == '0;
            sat_reg[0]  <= an_sh >= SW'(ad);
            for (int i = 0; i < QB; i++)
            begin
                logic [RW:0] tr;
                tr = {rem_reg[i], 1'b0};
                if (tr >= (RW+1)'(d_reg[i]))
                begin
                    rem_reg[i+1] <= RW'(tr - (RW+1)'(d_reg[i]));
                    q_reg[i+1]   <= {q_reg[i][QB-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[i+1] <= RW'(tr);
                    q_reg[i+1]   <= {q_reg[i][QB-2:0], 1'b0};
                end
                d_reg[i+1]    <= d_reg[i];
                neg_reg[i+1]  <= neg_reg[i];
                sat_reg[i+1]  <= sat_reg[i];
                zero_reg[i+1] <= zero_reg[i];
            end
            quo <= res;
        end
    end
endmodule

### sv/swept_box_collision_resolve_core.sv
// swept box collision resolve core, top level
// depends on sbcr_pkg and sbcr_div
// stream in on s_axis, one result item out on m_axis
//
// s_axis_tdata carries eleven 16-bit fields, m_axis_tdata carries eight
// the pipe has 1 + 19 + 3 = 23 register stages; one item may enter in every
// cycle in which the output is not stalled
// the whole pipe advances only when its last stage is empty or being taken,
// so a stalled receiver holds every stage and nothing is lost or repeated
// reset clears all valid bits; payload holds whatever it had
//
// slab times come from four restoring dividers, one quotient bit per stage
module swept_box_collision_resolve_core #(
    parameter int COORD_BITS = sbcr_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = sbcr_pkg::FRAC_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // mover_x, mover_y, mover_w, mover_h, vel_x, vel_y, step_time,
    // obstacle_x, obstacle_y, obstacle_w, obstacle_h
    input  logic [10*COORD_BITS+15:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // hit, entry time, contact_x, contact_y, normal_x, normal_y, new_vel_x, new_vel_y
    output logic [((4*COORD_BITS+22+7)/8)*8-1:0] m_axis_tdata
);
    import sbcr_pkg::*;
    localparam int C  = COORD_BITS;
    localparam int DW = C + 17;
    localparam int NW = C + 3;
    localparam int SD = QBITS + 2;
    localparam int LAT = SD + 4;
    localparam int OW = ((4*C+22+7)/8)*8;

    logic adv;
    logic [LAT-1:0] v_reg;
    assign adv = !v_reg[LAT-1] || m_axis_tready;
    assign s_axis_tready = adv;
    assign m_axis_tvalid = v_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[LAT-2:0], s_axis_tvalid};
    end

    // stage 1: unpack, products, slab bounds
    logic signed [C-1:0] mx, my, vx, vy, ox, oy;
    logic [C-1:0] mw, mh, ow, oh;
    logic [15:0] dt;
    assign mx = s_axis_tdata[0*C +: C];
    assign my = s_axis_tdata[1*C +: C];
    assign mw = s_axis_tdata[2*C +: C];
    assign mh = s_axis_tdata[3*C +: C];
    assign vx = s_axis_tdata[4*C +: C];
    assign vy = s_axis_tdata[5*C +: C];
    assign dt = s_axis_tdata[6*C +: 16];
    assign ox = s_axis_tdata[6*C+16 +: C];
    assign oy = s_axis_tdata[7*C+16 +: C];
    assign ow = s_axis_tdata[8*C+16 +: C];
    assign oh = s_axis_tdata[9*C+16 +: C];

    logic signed [DW-1:0] dx_reg, dy_reg;
    logic signed [NW-1:0] lx_reg, hx_reg, ly_reg, hy_reg;
    logic signed [C-1:0]  mx_reg, my_reg, vx_reg, vy_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dx_reg <= DW'(vx) * DW'($signed({1'b0, dt}));
            dy_reg <= DW'(vy) * DW'($signed({1'b0, dt}));
            lx_reg <= NW'(ox) - NW'($signed({1'b0, mw})) - NW'(mx);
            hx_reg <= NW'(ox) + NW'($signed({1'b0, ow})) - NW'(mx);
            ly_reg <= NW'(oy) - NW'($signed({1'b0, mh})) - NW'(my);
            hy_reg <= NW'(oy) + NW'($signed({1'b0, oh})) - NW'(my);
            mx_reg <= mx; my_reg <= my; vx_reg <= vx; vy_reg <= vy;
        end
    end

    // slab dividers, four in parallel
    logic signed [TW-1:0] tlx, thx, tly, thy;
    sbcr_div #(.NW(NW), .DW(DW)) u_dlx
        (.clk, .en(adv), .num(lx_reg), .den(dx_reg), .quo(tlx));
    sbcr_div #(.NW(NW), .DW(DW)) u_dhx
        (.clk, .en(adv), .num(hx_reg), .den(dx_reg), .quo(thx));
    sbcr_div #(.NW(NW), .DW(DW)) u_dly
        (.clk, .en(adv), .num(ly_reg), .den(dy_reg), .quo(tly));
    sbcr_div #(.NW(NW), .DW(DW)) u_dhy
        (.clk, .en(adv), .num(hy_reg), .den(dy_reg), .quo(thy));

    // side data delay line across the dividers
    logic signed [DW-1:0] sdx_reg [SD], sdy_reg [SD];
    logic signed [C-1:0]  smx_reg [SD], smy_reg [SD], svx_reg [SD], svy_reg [SD];
    logic                 ox_reg  [SD], oky_reg [SD];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sdx_reg[0] <= dx_reg; sdy_reg[0] <= dy_reg;
            smx_reg[0] <= mx_reg; smy_reg[0] <= my_reg;
            svx_reg[0] <= vx_reg; svy_reg[0] <= vy_reg;
            ox_reg[0]  <= !(lx_reg > 0 || hx_reg < 0);
            oky_reg[0] <= !(ly_reg > 0 || hy_reg < 0);
            for (int i = 1; i < SD; i++)
            begin
                sdx_reg[i] <= sdx_reg[i-1]; sdy_reg[i] <= sdy_reg[i-1];
                smx_reg[i] <= smx_reg[i-1]; smy_reg[i] <= smy_reg[i-1];
                svx_reg[i] <= svx_reg[i-1]; svy_reg[i] <= svy_reg[i-1];
                ox_reg[i]  <= ox_reg[i-1];  oky_reg[i] <= oky_reg[i-1];
            end
        end
    end

    // stage A: slab ordering and hit decision
    logic signed [DW-1:0] dxa, dya;
    logic signed [TW-1:0] nxt, fxt, nyt, fyt, tn, tf;
    logic hit_a;
    always_comb
    begin
        dxa = sdx_reg[SD-1];
        dya = sdy_reg[SD-1];
        if (dxa == '0)
        begin
            nxt = -T_SAT; fxt = T_SAT;
        end
        else if (dxa < 0)
        begin
            nxt = thx; fxt = tlx;
        end
        else
        begin
            nxt = tlx; fxt = thx;
        end
        if (dya == '0)
        begin
            nyt = -T_SAT; fyt = T_SAT;
        end
        else if (dya < 0)
        begin
            nyt = thy; fyt = tly;
        end
        else
        begin
            nyt = tly; fyt = thy;
        end
        tf = (fxt < fyt) ? fxt : fyt;
        tn = (nxt > nyt) ? nxt : nyt;
        hit_a = (dxa != '0 || dya != '0)
              && (dxa != '0 || ox_reg[SD-1]) && (dya != '0 || oky_reg[SD-1])
              && !(nxt > fyt || nyt > fxt)
              && tn <= T_ONE && tf >= 0 && tn >= 0;
    end

    logic hit_b_reg;
    logic signed [TW-1:0] tn_b_reg;
    logic signed [1:0] nx_b_reg, ny_b_reg;
    logic signed [DW-1:0] dx_b_reg, dy_b_reg;
    logic signed [C-1:0] mx_b_reg, my_b_reg, vx_b_reg, vy_b_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hit_b_reg <= hit_a;
            tn_b_reg  <= hit_a ? tn : '0;
            nx_b_reg  <= (hit_a && nxt > nyt) ? ((dxa < 0) ? 2'sd1 : -2'sd1) : 2'sd0;
            ny_b_reg  <= (hit_a && nxt < nyt) ? ((dya < 0) ? 2'sd1 : -2'sd1) : 2'sd0;
            dx_b_reg <= dxa; dy_b_reg <= dya;
            mx_b_reg <= smx_reg[SD-1]; my_b_reg <= smy_reg[SD-1];
            vx_b_reg <= svx_reg[SD-1]; vy_b_reg <= svy_reg[SD-1];
        end
    end

    // stage B: products for contact and velocity
    localparam int PW = DW + TW;
    logic signed [PW-1:0] px_c_reg, py_c_reg;
    logic [C+TW-1:0] ax_c_reg, ay_c_reg;
    logic [C-1:0] avx, avy;
    logic [TW-1:0] remt;
    logic hit_c_reg;
    logic signed [TW-1:0] tn_c_reg;
    logic signed [1:0] nx_c_reg, ny_c_reg;
    logic signed [C-1:0] mx_c_reg, my_c_reg, vx_c_reg, vy_c_reg;
    assign avx  = vx_b_reg[C-1] ? C'(-vx_b_reg) : C'(vx_b_reg);
    assign avy  = vy_b_reg[C-1] ? C'(-vy_b_reg) : C'(vy_b_reg);
    assign remt = TW'(T_ONE - tn_b_reg);
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            px_c_reg <= PW'(tn_b_reg) * PW'(dx_b_reg);
            py_c_reg <= PW'(tn_b_reg) * PW'(dy_b_reg);
            ax_c_reg <= (C+TW)'(avx) * (C+TW)'(remt);
            ay_c_reg <= (C+TW)'(avy) * (C+TW)'(remt);
            hit_c_reg <= hit_b_reg; tn_c_reg <= tn_b_reg;
            nx_c_reg <= nx_b_reg; ny_c_reg <= ny_b_reg;
            mx_c_reg <= mx_b_reg; my_c_reg <= my_b_reg;
            vx_c_reg <= vx_b_reg; vy_c_reg <= vy_b_reg;
        end
    end

    // stage C: sums and saturation
    function automatic logic [C-1:0] sat_c(input logic signed [C+2:0] v);
        logic signed [C+2:0] hi, lo;
        hi = (C+3)'((1 <<< (C-1)) - 1);
        lo = -hi - 1;
        if (v > hi) return C'(hi);
        if (v < lo) return C'(lo);
        return C'(v);
    endfunction

    logic signed [C+2:0] sx, sy, wx, wy;
    logic [C-1:0] cx, cy, nvx, nvy;
    always_comb
    begin
        sx = (C+3)'(mx_c_reg) + (C+3)'(px_c_reg >>> 32);
        sy = (C+3)'(my_c_reg) + (C+3)'(py_c_reg >>> 32);
        wx = (C+3)'(vx_c_reg) + (C+3)'(nx_c_reg) * (C+3)'({1'b0, ax_c_reg >> TIME_BITS});
        wy = (C+3)'(vy_c_reg) + (C+3)'(ny_c_reg) * (C+3)'({1'b0, ay_c_reg >> TIME_BITS});
        cx  = hit_c_reg ? sat_c(sx) : '0;
        cy  = hit_c_reg ? sat_c(sy) : '0;
        nvx = hit_c_reg ? sat_c(wx) : C'(vx_c_reg);
        nvy = hit_c_reg ? sat_c(wy) : C'(vy_c_reg);
    end

    logic [OW-1:0] out_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
            out_reg <= OW'({nvy, nvx, ny_c_reg, nx_c_reg, cy, cx,
                            17'(tn_c_reg), hit_c_reg});
    end
    assign m_axis_tdata = out_reg;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result lost under stall");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input refused with empty output");
endmodule
